FILE: rtl/megm_pkg.sv
package megm_pkg;

  localparam int MaxSide    = 64;
  localparam int CoordBits  = 20;
  localparam int SideBits   = $clog2(MaxSide + 1);
  localparam int IdxBits    = $clog2(MaxSide * MaxSide);
  localparam int Depth      = MaxSide * MaxSide;
  localparam int CsBits     = 16;
  localparam int DiffBits   = CoordBits + 1;
  localparam int MagBits    = DiffBits + 1;
  localparam int QuoBits    = MagBits;
  localparam int CfgIdxBits = 3;
  localparam int CfgBits    = CoordBits;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IN_VEHICLE = 3'd0,
    ST_OFF_GRID   = 3'd1,
    ST_NOT_HIGHER = 3'd2,
    ST_RAISED     = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_BAD_INDEX  = 3'd5,
    ST_CLEARED    = 3'd6
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_VX_MIN = 3'd0,
    CFG_VX_MAX = 3'd1,
    CFG_VY_MIN = 3'd2,
    CFG_VY_MAX = 3'd3,
    CFG_ORG_X  = 3'd4,
    CFG_ORG_Y  = 3'd5,
    CFG_CELL   = 3'd6,
    CFG_SIDE   = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_DIV,
    FSM_READ,
    FSM_WAIT,
    FSM_WRITE,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_start;
    logic rd;
    logic wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic is_insert;
    logic is_none;
    logic direct;
  } sts_t;

endpackage

FILE: rtl/megm_if.sv
interface megm_in_if;
  import megm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic signed [CoordBits-1:0] sensor_x;
  logic signed [CoordBits-1:0] sensor_y;
  logic signed [CoordBits-1:0] map_x;
  logic signed [CoordBits-1:0] map_y;
  logic signed [CoordBits-1:0] map_z;
  logic                        on_road;
  logic [IdxBits-1:0]          cell_index;
  modport source (output valid, req_type, sensor_x, sensor_y, map_x, map_y, map_z,
                  on_road, cell_index, input ready);
  modport sink   (input valid, req_type, sensor_x, sensor_y, map_x, map_y, map_z,
                  on_road, cell_index, output ready);
endinterface

interface megm_out_if;
  import megm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [IdxBits-1:0]          hit_cell;
  logic signed [CoordBits-1:0] elevation;
  logic                        traversable;
  modport source (output valid, status, hit_cell, elevation, traversable, input ready);
  modport sink   (input valid, status, hit_cell, elevation, traversable, output ready);
endinterface

FILE: rtl/max_elevation_grid_map_unit.sv
// channel  dir  payload
// pnt_in   in   req_type sensor_x/y map_x/y/z on_road cell_index
// res_out  out  status hit_cell elevation traversable
// cfg      in   cfg_we_i cfg_idx_i cfg_data_i
// One transaction at a time. An insert runs the 22-step restoring divider that bins both
// coordinates side by side; off-grid inserts also pass through it, while in-vehicle
// inserts, reads, clears and bad indices skip it.
// After reset a clearing sweep over all 4096 cells runs before the first input.
// A result waits in the output register; the next input is taken meanwhile.
module max_elevation_grid_map_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [megm_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [megm_pkg::CfgBits-1:0]    cfg_data_i,
  megm_in_if.sink                         pnt_in,
  megm_out_if.source                      res_out
);
  import megm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  megm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pnt_in.valid),
    .in_ready_o  (pnt_in.ready),
    .out_valid_o (res_out.valid),
    .out_ready_i (res_out.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  megm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (pnt_in.req_type),
    .sensor_x_i    (pnt_in.sensor_x),
    .sensor_y_i    (pnt_in.sensor_y),
    .map_x_i       (pnt_in.map_x),
    .map_y_i       (pnt_in.map_y),
    .map_z_i       (pnt_in.map_z),
    .on_road_i     (pnt_in.on_road),
    .cell_index_i  (pnt_in.cell_index),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (res_out.status),
    .hit_cell_o    (res_out.hit_cell),
    .elevation_o   (res_out.elevation),
    .traversable_o (res_out.traversable)
  );

endmodule

FILE: rtl/megm_div.sv
module megm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [megm_pkg::MagBits-1:0]  num_a_i,
  input  logic [megm_pkg::MagBits-1:0]  num_b_i,
  input  logic [megm_pkg::CsBits:0]     den_i,
  output logic                          done_o,
  output logic [megm_pkg::QuoBits-1:0]  quo_a_o,
  output logic [megm_pkg::QuoBits-1:0]  quo_b_o
);
  import megm_pkg::*;

  localparam int CntBits = $clog2(MagBits + 1);

  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [MagBits-1:0]    qa_q, qa_d, qb_q, qb_d;
  logic [CsBits+1:0]     ra_q, ra_d, rb_q, rb_d;
  logic [CsBits:0]       den_q;
  logic [CsBits+1:0]     ta, tb;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    qa_d   = qa_q;
    qb_d   = qb_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    ta     = {ra_q[CsBits:0], qa_q[MagBits-1]};
    tb     = {rb_q[CsBits:0], qb_q[MagBits-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(MagBits);
      qa_d   = num_a_i;
      qb_d   = num_b_i;
      ra_d   = '0;
      rb_d   = '0;
    end else if (busy_q) begin
      qa_d = {qa_q[MagBits-2:0], 1'b0};
      qb_d = {qb_q[MagBits-2:0], 1'b0};
      if (ta >= {1'b0, den_q}) begin
        ra_d = ta - {1'b0, den_q};
        qa_d[0] = 1'b1;
      end else begin
        ra_d = ta;
      end
      if (tb >= {1'b0, den_q}) begin
        rb_d = tb - {1'b0, den_q};
        qb_d[0] = 1'b1;
      end else begin
        rb_d = tb;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qa_q <= qa_d;
    qb_q <= qb_d;
    ra_q <= ra_d;
    rb_q <= rb_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o  = busy_q && (cnt_q == CntBits'(1));
  assign quo_a_o = qa_d;
  assign quo_b_o = qb_d;

endmodule

FILE: rtl/megm_ctrl.sv
module megm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  megm_pkg::sts_t sts_i,
  output megm_pkg::cmd_t cmd_o
);
  import megm_pkg::*;

  fsm_e state_q, state_d;
  logic ov_q, ov_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ov_d       = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      FSM_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = FSM_IDLE;
      end
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = FSM_DIV;
        end
      end
      FSM_DIV: begin
        if (sts_i.is_none) begin
          state_d = FSM_IDLE;
        end else if (!sts_i.is_insert) begin
          state_d = sts_i.direct ? FSM_OUT : FSM_READ;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = FSM_WAIT;
        end
      end
      FSM_WAIT: begin
        if (sts_i.div_done) state_d = FSM_READ;
      end
      FSM_READ: begin
        if (sts_i.direct) begin
          state_d = FSM_OUT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = FSM_WRITE;
        end
      end
      FSM_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = FSM_OUT;
      end
      FSM_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_CLEAR;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == FSM_IDLE) else $error("ready outside idle");
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr |-> $past(cmd_o.rd)) else $error("write without read");
  a_load_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!ov_q || out_ready_i)) else $error("result overwritten");

endmodule

FILE: rtl/megm_dp.sv
module megm_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [megm_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [megm_pkg::CfgBits-1:0]         cfg_data_i,
  input  logic [1:0]                           req_type_i,
  input  logic signed [megm_pkg::CoordBits-1:0] sensor_x_i,
  input  logic signed [megm_pkg::CoordBits-1:0] sensor_y_i,
  input  logic signed [megm_pkg::CoordBits-1:0] map_x_i,
  input  logic signed [megm_pkg::CoordBits-1:0] map_y_i,
  input  logic signed [megm_pkg::CoordBits-1:0] map_z_i,
  input  logic                                 on_road_i,
  input  logic [megm_pkg::IdxBits-1:0]         cell_index_i,
  input  megm_pkg::cmd_t                       cmd_i,
  output megm_pkg::sts_t                       sts_o,
  output logic [2:0]                           status_o,
  output logic [megm_pkg::IdxBits-1:0]         hit_cell_o,
  output logic signed [megm_pkg::CoordBits-1:0] elevation_o,
  output logic                                 traversable_o
);
  import megm_pkg::*;

  localparam logic signed [CoordBits-1:0] ElevMin = {1'b1, {(CoordBits-1){1'b0}}};

  logic signed [CoordBits-1:0] vx_min_q, vx_max_q, vy_min_q, vy_max_q, org_x_q, org_y_q;
  logic [CsBits-1:0]           cs_q;
  logic [6:0]                  side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_min_q <= -CoordBits'(512);
      vx_max_q <= CoordBits'(512);
      vy_min_q <= -CoordBits'(256);
      vy_max_q <= CoordBits'(256);
      org_x_q  <= '0;
      org_y_q  <= '0;
      cs_q     <= CsBits'(51);
      side_q   <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_VX_MIN: vx_min_q <= cfg_data_i;
        CFG_VX_MAX: vx_max_q <= cfg_data_i;
        CFG_VY_MIN: vy_min_q <= cfg_data_i;
        CFG_VY_MAX: vy_max_q <= cfg_data_i;
        CFG_ORG_X:  org_x_q  <= cfg_data_i;
        CFG_ORG_Y:  org_y_q  <= cfg_data_i;
        CFG_CELL:   cs_q     <= cfg_data_i[CsBits-1:0];
        CFG_SIDE:   side_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [SideBits-1:0] side;
  assign side = (side_q > 7'(MaxSide)) ? SideBits'(MaxSide) : SideBits'(side_q);

  // latched request
  req_e                        req_q;
  logic signed [CoordBits-1:0] z_q;
  logic                        road_q;
  logic [IdxBits-1:0]          idx_q;
  logic signed [DiffBits-1:0]  dx_q, dy_q;
  logic                        inveh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_e'(req_type_i);
      z_q     <= map_z_i;
      road_q  <= on_road_i;
      idx_q   <= cell_index_i;
      dx_q    <= DiffBits'(map_x_i) - DiffBits'(org_x_q);
      dy_q    <= DiffBits'(map_y_i) - DiffBits'(org_y_q);
      inveh_q <= (sensor_x_i < vx_max_q) && (sensor_x_i > vx_min_q) &&
                 (sensor_y_i > vy_min_q) && (sensor_y_i < vy_max_q);
    end
  end

  // rounding: q = (2|d| + cs) / (2cs)
  logic [CsBits-1:0]  cs_eff;
  logic [MagBits-1:0] mag_x, mag_y, num_x, num_y;
  logic [QuoBits-1:0] qx, qy;
  logic               div_done;
  assign cs_eff = (cs_q == '0) ? CsBits'(1) : cs_q;
  assign mag_x  = dx_q[DiffBits-1] ? MagBits'(-dx_q) : MagBits'(dx_q);
  assign mag_y  = dy_q[DiffBits-1] ? MagBits'(-dy_q) : MagBits'(dy_q);
  assign num_x  = {mag_x[MagBits-2:0], 1'b0} + MagBits'(cs_eff);
  assign num_y  = {mag_y[MagBits-2:0], 1'b0} + MagBits'(cs_eff);

  megm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_a_i (num_x),
    .num_b_i (num_y),
    .den_i   ({cs_eff, 1'b0}),
    .done_o  (div_done),
    .quo_a_o (qx),
    .quo_b_o (qy)
  );

  logic [QuoBits-1:0] col_q, row_q;
  logic               off_q;
  logic               neg_x, neg_y;
  assign neg_x = dx_q[DiffBits-1] && (qx != '0);
  assign neg_y = dy_q[DiffBits-1] && (qy != '0);

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      col_q <= qx;
      row_q <= qy;
      off_q <= neg_x || neg_y || (qx >= QuoBits'(side)) || (qy >= QuoBits'(side));
    end
  end

  logic [2*SideBits-1:0] area, lin;
  logic [IdxBits-1:0]    addr;
  assign area = side * side;
  assign lin  = (2*SideBits)'(row_q[SideBits-1:0]) * (2*SideBits)'(side)
              + (2*SideBits)'(col_q[SideBits-1:0]);
  assign addr = (req_q == REQ_INSERT) ? lin[IdxBits-1:0] : idx_q;

  logic bad_idx;
  assign bad_idx = (2*SideBits)'(idx_q) >= area;

  // store, cleared by a sweep after reset
  logic signed [CoordBits-1:0] elev_mem [Depth];
  logic                        lab_mem  [Depth];
  logic [IdxBits:0]            clr_q;
  logic signed [CoordBits-1:0] rd_e_q;
  logic                        rd_l_q;
  logic signed [CoordBits-1:0] wr_e;
  logic                        wr_l;
  logic                        wr_en;
  logic [IdxBits-1:0]          wr_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  logic raise;
  assign raise = (req_q == REQ_INSERT) && (z_q > rd_e_q);

  always_comb begin
    wr_en = 1'b0;
    wr_a  = addr;
    wr_e  = z_q;
    wr_l  = road_q;
    if (cmd_i.clr_step) begin
      wr_en = 1'b1;
      wr_a  = clr_q[IdxBits-1:0];
      wr_e  = ElevMin;
      wr_l  = 1'b0;
    end else if (cmd_i.wr) begin
      if (req_q == REQ_CLEAR) begin
        wr_en = 1'b1;
        wr_e  = ElevMin;
        wr_l  = 1'b0;
      end else if (raise) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      elev_mem[wr_a] <= wr_e;
      lab_mem[wr_a]  <= wr_l;
    end
    if (cmd_i.rd) begin
      rd_e_q <= elev_mem[addr];
      rd_l_q <= lab_mem[addr];
    end
  end

  logic direct;
  assign direct = (req_q == REQ_INSERT) ? (inveh_q || off_q) : bad_idx;

  assign sts_o.clr_done  = clr_q == (IdxBits+1)'(Depth - 1);
  assign sts_o.div_done  = div_done;
  assign sts_o.is_insert = (req_q == REQ_INSERT) && !inveh_q;
  assign sts_o.is_none   = req_q == REQ_NONE;
  assign sts_o.direct    = direct;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      hit_cell_o    <= '0;
      elevation_o   <= '0;
      traversable_o <= 1'b0;
      if (req_q == REQ_INSERT) begin
        if (inveh_q) begin
          status_o <= ST_IN_VEHICLE;
        end else if (off_q) begin
          status_o <= ST_OFF_GRID;
        end else begin
          status_o      <= raise ? ST_RAISED : ST_NOT_HIGHER;
          hit_cell_o    <= addr;
          elevation_o   <= raise ? z_q : rd_e_q;
          traversable_o <= raise ? road_q : rd_l_q;
        end
      end else begin
        hit_cell_o <= idx_q;
        if (bad_idx) begin
          status_o <= ST_BAD_INDEX;
        end else if (req_q == REQ_CLEAR) begin
          status_o    <= ST_CLEARED;
          elevation_o <= ElevMin;
        end else begin
          status_o      <= ST_READ_OK;
          elevation_o   <= rd_e_q;
          traversable_o <= rd_l_q;
        end
      end
    end
  end

endmodule
